// ===== rtl/ip_address_table_mask_filter_unit_defines.svh =====
// Assertion macros for the IPv4 address table with mask filter.
// Included by the top level; no other dependencies.
`ifndef IP_ADDRESS_TABLE_MASK_FILTER_UNIT_DEFINES_SVH
`define IP_ADDRESS_TABLE_MASK_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define IPTMF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define IPTMF_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define IPTMF_ASSERT(label, clk, rst, prop)
`define IPTMF_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== rtl/iptmf_pkg.sv =====
// Shared codes, constants and types for the IPv4 address table with mask filter.
// No dependencies.
`timescale 1ns / 1ps

package iptmf_pkg;

  // Command codes.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FILTER = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NO_MATCH  = 2'd3;

  // Category codes.
  localparam logic [1:0] CAT_PRIVATE = 2'd0;
  localparam logic [1:0] CAT_SPECIAL = 2'd1;
  localparam logic [1:0] CAT_PUBLIC  = 2'd2;

  // Address class codes.
  localparam logic [2:0] CLS_A    = 3'd0;
  localparam logic [2:0] CLS_B    = 3'd1;
  localparam logic [2:0] CLS_C    = 3'd2;
  localparam logic [2:0] CLS_D    = 3'd3;
  localparam logic [2:0] CLS_E    = 3'd4;
  localparam logic [2:0] CLS_NONE = 3'd5;

  // Octet boundaries used by the classifier.
  localparam logic [7:0] OCT_PRIV_A    = 8'd10;
  localparam logic [7:0] OCT_PRIV_B    = 8'd172;
  localparam logic [7:0] OCT_PRIV_B_LO = 8'd16;
  localparam logic [7:0] OCT_PRIV_B_HI = 8'd31;
  localparam logic [7:0] OCT_PRIV_C    = 8'd192;
  localparam logic [7:0] OCT_PRIV_C2   = 8'd168;
  localparam logic [7:0] OCT_LOOPBACK  = 8'd127;
  localparam logic [7:0] CLS_A_MAX     = 8'd126;
  localparam logic [7:0] CLS_B_MAX     = 8'd191;
  localparam logic [7:0] CLS_C_MAX     = 8'd223;
  localparam logic [7:0] CLS_D_MAX     = 8'd239;

  localparam logic [31:0] LOOPBACK_ADDR = 32'h7F00_0001;

  typedef struct packed {
    logic [1:0] category;
    logic [2:0] addr_class;
  } class_info_t;

endpackage

// ===== rtl/iptmf_in_if.sv =====
// Request channel of the IPv4 address table: command, address and mask.
// No dependencies.
`timescale 1ns / 1ps

interface iptmf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] address;
  logic [31:0] mask;

  modport source (output valid, output cmd, output address, output mask, input ready);
  modport sink (input valid, input cmd, input address, input mask, output ready);
endinterface

// ===== rtl/iptmf_out_if.sv =====
// Result channel of the IPv4 address table: entry, status and classification.
// No dependencies.
`timescale 1ns / 1ps

interface iptmf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] entry_address;
  logic [1:0]  status;
  logic [1:0]  category;
  logic [2:0]  addr_class;
  logic        last;

  modport source (output valid, output entry_address, output status, output category,
                  output addr_class, output last, input ready);
  modport sink (input valid, input entry_address, input status, input category,
                input addr_class, input last, output ready);
endinterface

// ===== rtl/iptmf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module iptmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/iptmf_classify.sv =====
// Category and address class decode of one IPv4 address.
// Depends on iptmf_pkg.
`timescale 1ns / 1ps

module iptmf_classify import iptmf_pkg::*; (
  input  logic [31:0] addr,
  output class_info_t info
);

  logic [7:0] o0;
  logic [7:0] o1;
  logic       is_private;

  assign o0 = addr[31:24];
  assign o1 = addr[23:16];

  // Private ranges cover 10/8, 172.16/12 and the whole 192.168/16.
  assign is_private = (o0 == OCT_PRIV_A) ||
                      (o0 == OCT_PRIV_B && o1 >= OCT_PRIV_B_LO && o1 <= OCT_PRIV_B_HI) ||
                      (o0 == OCT_PRIV_C && o1 == OCT_PRIV_C2);

  always_comb begin
    if (is_private) begin
      info.category = CAT_PRIVATE;
    end else if (addr == LOOPBACK_ADDR) begin
      info.category = CAT_SPECIAL;
    end else begin
      info.category = CAT_PUBLIC;
    end

    if (o0 <= CLS_A_MAX) begin
      info.addr_class = CLS_A;
    end else if (o0 == OCT_LOOPBACK) begin
      info.addr_class = CLS_NONE;
    end else if (o0 <= CLS_B_MAX) begin
      info.addr_class = CLS_B;
    end else if (o0 <= CLS_C_MAX) begin
      info.addr_class = CLS_C;
    end else if (o0 <= CLS_D_MAX) begin
      info.addr_class = CLS_D;
    end else begin
      info.addr_class = CLS_E;
    end
  end

endmodule

// ===== rtl/ip_address_table_mask_filter_unit.sv =====
// IPv4 address table with mask filter: insert, remove with gap closing, filter.
// Insert writes at the count unless the table is full, in the accepting cycle; its result is
// loaded from the done state, and the next request is accepted as it is loaded. Remove and
// filter read one entry per cycle, filter only while the result channel takes its matches. One request at a time.
// Synchronous reset empties the table (count zero); RAM contents are not cleared.
// Depends on iptmf_pkg, iptmf_in_if, iptmf_out_if, iptmf_ram, iptmf_classify.
`timescale 1ns / 1ps
`include "ip_address_table_mask_filter_unit_defines.svh"

module ip_address_table_mask_filter_unit import iptmf_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  iptmf_in_if.sink    req,
  iptmf_out_if.source rsp
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [1:0]    cmd_q;
  logic [31:0]   addr_q;
  logic [31:0]   mask_q;
  logic [CW-1:0] rd_idx;
  logic          pipe_vld;
  logic [AW-1:0] pipe_idx;
  logic          found;
  logic          pend_vld;
  logic [31:0]   pend_addr;
  logic [1:0]    done_status;
  logic          out_valid;

  logic          accept;
  logic          insert_ok;
  logic          emit_ok;
  logic          is_filter;
  logic          hit_eq;
  logic          hit_mask;
  logic          stall;
  logic          issue;
  logic          walk_end;
  logic          load_walk;
  logic          load_done;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re;
  logic [31:0]   rdata;
  class_info_t   pend_info;

  iptmf_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rdata)
  );

  iptmf_classify u_classify (
    .addr (pend_addr),
    .info (pend_info)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign insert_ok = accept && (req.cmd == CMD_INSERT) && (count < DEPTH_C);
  assign emit_ok   = !out_valid || rsp.ready;
  assign is_filter = (cmd_q == CMD_FILTER);
  assign hit_eq    = (rdata == addr_q);
  assign hit_mask  = ((rdata & mask_q) == mask_q);

  // A new match must push the previous one out; hold the walk if the
  // output register cannot take it.
  assign stall    = pipe_vld && is_filter && hit_mask && pend_vld && !emit_ok;
  assign issue    = (rd_idx != count);
  assign walk_end = !issue && !pipe_vld;
  assign ram_re   = (state == S_WALK) && !stall && issue;

  assign load_walk = (state == S_WALK) && pipe_vld && is_filter && hit_mask &&
                     pend_vld && emit_ok;
  assign load_done = (state == S_DONE) && emit_ok;

  // Insert appends at the count; remove shifts each entry after the hit down by one.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = req.address;
    if (insert_ok) begin
      ram_we = 1'b1;
    end else if (state == S_WALK && pipe_vld && !is_filter && found) begin
      ram_we    = 1'b1;
      ram_waddr = pipe_idx - 1'b1;
      ram_wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pipe_vld  <= 1'b0;
      found     <= 1'b0;
      pend_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_walk || load_done) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q    <= req.cmd;
            addr_q   <= req.address;
            mask_q   <= req.mask;
            rd_idx   <= '0;
            pipe_vld <= 1'b0;
            found    <= 1'b0;
            pend_vld <= 1'b0;
            unique case (req.cmd) inside
              CMD_INSERT: begin
                if (count < DEPTH_C) begin
                  count       <= count + 1'b1;
                  done_status <= ST_OK;
                end else begin
                  done_status <= ST_FULL;
                end
                state <= S_DONE;
              end
              CMD_REMOVE, CMD_FILTER: begin
                state <= S_WALK;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_WALK: begin
          if (!stall) begin
            if (issue) begin
              rd_idx <= rd_idx + 1'b1;
            end
            pipe_vld <= issue;
            pipe_idx <= rd_idx[AW-1:0];
            if (pipe_vld) begin
              if (is_filter) begin
                if (hit_mask) begin
                  pend_addr <= rdata;
                  pend_vld  <= 1'b1;
                end
              end else if (!found && hit_eq) begin
                found <= 1'b1;
              end
            end
            if (walk_end) begin
              state <= S_DONE;
              if (!is_filter) begin
                done_status <= found ? ST_OK : ST_NOT_FOUND;
                if (found) begin
                  count <= count - 1'b1;
                end
              end
            end
          end
        end
        S_DONE: begin
          if (emit_ok) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load_walk) begin
      rsp.entry_address <= pend_addr;
      rsp.status        <= ST_OK;
      rsp.category      <= pend_info.category;
      rsp.addr_class    <= pend_info.addr_class;
      rsp.last          <= 1'b0;
    end else if (load_done) begin
      rsp.last <= 1'b1;
      if (is_filter && pend_vld) begin
        rsp.entry_address <= pend_addr;
        rsp.status        <= ST_OK;
        rsp.category      <= pend_info.category;
        rsp.addr_class    <= pend_info.addr_class;
      end else begin
        rsp.entry_address <= '0;
        rsp.status        <= is_filter ? ST_NO_MATCH : done_status;
        rsp.category      <= CAT_PRIVATE;
        rsp.addr_class    <= CLS_A;
      end
    end
  end

  assign rsp.valid = out_valid;

  `IPTMF_ASSERT(a_insert_grows, clk, rst, insert_ok |=> (count == $past(count) + 1'b1))
  `IPTMF_NEVER(a_filter_read_only, clk, rst, ram_we && state == S_WALK && is_filter)
  `IPTMF_ASSERT(a_stall_holds_match, clk, rst, (state == S_WALK && stall) |=> $stable(pend_addr))

endmodule
